FILE: rtl/prwc_pkg.sv
// Shared types, register codes and widths for the PNM raster window converter.
package prwc_pkg;

    // Widths of the configuration port, of the position counters and of the divider.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int COL_BITS   = 19;
    localparam int POS_BITS   = 20;
    localparam int REM_W      = 34;
    localparam int QUO_W      = 17;
    localparam int CNT_W      = 5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_X      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_Y      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_KIND    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_VALUE     = 3'd7;

    // Pixel kind codes.
    localparam logic [1:0] KIND_BITMAP = 2'd0;
    localparam logic [1:0] KIND_GREY   = 2'd1;

    // Divider step on which only the saturation check is made.
    localparam logic [CNT_W-1:0] DIV_FIRST = 5'd17;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_EVAL,
        ST_DIV,
        ST_EMIT0,
        ST_EMIT1
    } t_state;

    // Settings derived from the configuration registers.
    typedef struct packed {
        logic [POS_BITS-1:0] stride;
        logic [POS_BITS-1:0] start;
        logic [POS_BITS-1:0] endb;
        logic [POS_BITS-1:0] plen;
        logic [POS_BITS-1:0] wlen;
        logic [15:0]         win_y;
        logic [16:0]         win_end;
        logic [15:0]         img_h;
        logic [2:0]          shift;
        logic                bitmap;
        logic                two;
        logic                skip;
        logic [15:0]         maxv;
    } t_cfg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic eval;
        logic div_step;
        logic sel_hi;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] eval_beats;
        logic       need_div;
        logic [1:0] beats;
        logic       div_last;
    } t_sts;

endpackage

FILE: rtl/prwc_cfg_regs.sv
// Configuration register bank and the row geometry derived from it.
module prwc_cfg_regs
    import prwc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    logic [15:0] r_image_width, r_image_height, r_window_x, r_window_y;
    logic [15:0] r_window_width, r_window_height, r_max_value;
    logic [1:0]  r_pixel_kind;
    t_cfg        r_cfg, n_cfg;

    // Number of bits covered by x pixels.
    function automatic logic [22:0] f_bits(input logic [16:0] x, input logic bitmap,
                                           input logic rgb, input logic two);
        logic [22:0] base;
        base = two ? ({6'd0, x} << 4) : ({6'd0, x} << 3);
        if (bitmap) begin
            f_bits = {6'd0, x};
        end else if (rgb) begin
            f_bits = (base << 1) + base;
        end else begin
            f_bits = base;
        end
    endfunction

    // Bits rounded up to whole bytes.
    function automatic logic [POS_BITS-1:0] f_ceil8(input logic [22:0] y);
        logic [23:0] sum;
        sum = {1'b0, y} + 24'd7;
        f_ceil8 = sum[22:3];
    endfunction

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width   <= 16'd1;
            r_image_height  <= 16'd1;
            r_window_x      <= 16'd0;
            r_window_y      <= 16'd0;
            r_window_width  <= 16'd1;
            r_window_height <= 16'd1;
            r_pixel_kind    <= KIND_GREY;
            r_max_value     <= 16'd255;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH:   r_image_width   <= i_cfg_data;
                REG_IMAGE_HEIGHT:  r_image_height  <= i_cfg_data;
                REG_WINDOW_X:      r_window_x      <= i_cfg_data;
                REG_WINDOW_Y:      r_window_y      <= i_cfg_data;
                REG_WINDOW_WIDTH:  r_window_width  <= i_cfg_data;
                REG_WINDOW_HEIGHT: r_window_height <= i_cfg_data;
                REG_PIXEL_KIND:    r_pixel_kind    <= i_cfg_data[1:0];
                REG_MAX_VALUE:     r_max_value     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Geometry of the file row and of the rectangle in bytes.
    always_comb begin
        logic        bitmap, rgb, two;
        logic [15:0] m;
        logic [16:0] wx_ww;
        logic [22:0] start_bits;
        bitmap = (r_pixel_kind == KIND_BITMAP);
        rgb    = !bitmap && (r_pixel_kind != KIND_GREY);
        m      = (r_max_value == 16'd0) ? 16'd1 : r_max_value;
        two    = !bitmap && (m > 16'd255);
        wx_ww  = {1'b0, r_window_x} + {1'b0, r_window_width};
        start_bits = f_bits({1'b0, r_window_x}, bitmap, rgb, two);

        n_cfg.stride  = f_ceil8(f_bits({1'b0, r_image_width}, bitmap, rgb, two));
        n_cfg.start   = start_bits[22:3];
        n_cfg.endb    = f_ceil8(f_bits(wx_ww, bitmap, rgb, two));
        n_cfg.wlen    = f_ceil8(f_bits({1'b0, r_window_width}, bitmap, rgb, two));
        n_cfg.plen    = n_cfg.endb - n_cfg.start;
        n_cfg.win_y   = r_window_y;
        n_cfg.win_end = {1'b0, r_window_y} + {1'b0, r_window_height};
        n_cfg.img_h   = r_image_height;
        n_cfg.shift   = r_window_x[2:0];
        n_cfg.bitmap  = bitmap;
        n_cfg.two     = two;
        n_cfg.skip    = two ? (m == 16'hFFFF) : (m == 16'd255);
        n_cfg.maxv    = m;
    end

    always_ff @(posedge i_clk) begin
        r_cfg <= n_cfg;
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/prwc_ctrl.sv
// Controller state machine: sequences load, evaluation, rescaling and output beats.
module prwc_ctrl
    import prwc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_stall,
    input  t_sts i_sts,
    output logic o_in_stall,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_LOAD;
            end
            ST_LOAD: n_state = ST_EVAL;
            ST_EVAL: begin
                if (i_sts.need_div) n_state = ST_DIV;
                else if (i_sts.eval_beats != 2'd0) n_state = ST_EMIT0;
                else n_state = ST_IDLE;
            end
            ST_DIV: begin
                if (i_sts.div_last) n_state = ST_EMIT0;
            end
            ST_EMIT0: begin
                if (!i_out_stall) n_state = (i_sts.beats == 2'd2) ? ST_EMIT1 : ST_IDLE;
            end
            ST_EMIT1: begin
                if (!i_out_stall) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_in_stall      = (r_state != ST_IDLE);
        o_out_valid     = (r_state inside {ST_EMIT0, ST_EMIT1});
        o_cmd.load      = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.eval      = (r_state == ST_EVAL);
        o_cmd.div_step  = (r_state == ST_DIV);
        o_cmd.sel_hi    = (r_state == ST_EMIT1);
    end

endmodule

FILE: rtl/prwc_dpath.sv
// Datapath: raster position, window test, bitmap shift, byte swap and rescaling divider.
module prwc_dpath
    import prwc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_raster_byte,
    input  t_cfg        i_cfg,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    output logic [7:0]  o_out_byte,
    output logic        o_row_end,
    output logic        o_window_end
);

    logic [7:0]          r_byte, r_held, r_b0, r_b1;
    logic [COL_BITS-1:0] r_col;
    logic [15:0]         r_row;
    logic [1:0]          r_beats;
    logic                r_flag_row, r_flag_win;
    logic [REM_W-1:0]    r_rem;
    logic [16:0]         r_den;
    logic [QUO_W-1:0]    r_quo;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_sat;

    // Evaluation results for the beat just loaded.
    logic [1:0]          e_beats;
    logic [7:0]          e_b0, e_b1, e_held;
    logic                e_need_div, e_flag_row, e_flag_win;
    logic [15:0]         e_v;
    logic [COL_BITS-1:0] e_col;
    logic [15:0]         e_row;

    always_comb begin
        logic [POS_BITS-1:0] col_ext, k, col_inc;
        logic [16:0]         row_inc;
        logic                inwin, last;
        logic [7:0]          inv, inv_sh, held_sh, inv_lo;
        col_ext = {1'b0, r_col};
        k       = col_ext - i_cfg.start;
        last    = ((k + 20'd1) == i_cfg.plen);
        inwin   = (r_row >= i_cfg.win_y) && ({1'b0, r_row} < i_cfg.win_end) &&
                  (i_cfg.wlen != '0) && (col_ext >= i_cfg.start) && (col_ext < i_cfg.endb);
        inv     = ~r_byte;
        inv_sh  = inv << i_cfg.shift;
        held_sh = r_held << i_cfg.shift;
        inv_lo  = inv >> (4'd8 - {1'b0, i_cfg.shift});

        e_beats    = 2'd0;
        e_b0       = r_byte;
        e_b1       = 8'd0;
        e_held     = r_held;
        e_need_div = 1'b0;
        e_v        = {8'd0, r_byte};

        if (inwin) begin
            if (i_cfg.bitmap) begin
                if (i_cfg.shift == 3'd0) begin
                    e_beats = 2'd1;
                    e_b0    = inv;
                end else if (k == '0) begin
                    e_held = inv;
                    if (i_cfg.plen == 20'd1) begin
                        e_beats = 2'd1;
                        e_b0    = inv_sh;
                    end
                end else begin
                    e_b0   = held_sh | inv_lo;
                    e_held = inv;
                    e_b1   = inv_sh;
                    e_beats = (last && (i_cfg.plen == i_cfg.wlen)) ? 2'd2 : 2'd1;
                end
            end else if (!i_cfg.two) begin
                e_beats    = 2'd1;
                e_need_div = !i_cfg.skip;
            end else if (!k[0]) begin
                e_held = r_byte;
            end else begin
                e_v        = {r_held, r_byte};
                e_b0       = r_byte;
                e_b1       = r_held;
                e_beats    = 2'd2;
                e_need_div = !i_cfg.skip;
            end
        end
        e_flag_row = inwin && last && (e_beats != 2'd0);
        e_flag_win = e_flag_row && ({1'b0, r_row} == (i_cfg.win_end - 17'd1));

        // Position after this byte.
        col_inc = col_ext + 20'd1;
        row_inc = {1'b0, r_row} + 17'd1;
        if (col_inc >= i_cfg.stride) begin
            e_col = '0;
            e_row = (row_inc >= {1'b0, i_cfg.img_h}) ? 16'd0 : row_inc[15:0];
        end else begin
            e_col = col_inc[COL_BITS-1:0];
            e_row = r_row;
        end
    end

    // Restoring divider step: compare the remainder with the shifted divisor.
    logic [REM_W-1:0] d_trial;
    logic             d_ge;
    logic [QUO_W-1:0] d_quo, d_res;
    logic             d_over;
    always_comb begin
        d_trial = {{(REM_W-17){1'b0}}, r_den} << r_cnt;
        d_ge    = (r_rem >= d_trial);
        d_quo   = {r_quo[QUO_W-2:0], d_ge};
        d_over  = r_sat || (i_cfg.two ? (d_quo > 17'd65535) : (d_quo > 17'd255));
        d_res   = d_over ? (i_cfg.two ? 17'd65535 : 17'd255) : d_quo;
    end

    // Position counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_held <= 8'd0;
        end else if (i_cmd.eval) begin
            r_col  <= e_col;
            r_row  <= e_row;
            r_held <= e_held;
        end
    end

    // Input byte, output beats and divider.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte <= i_raster_byte;
        end
        if (i_cmd.eval) begin
            r_beats    <= e_beats;
            r_b0       <= e_b0;
            r_b1       <= e_b1;
            r_flag_row <= e_flag_row;
            r_flag_win <= e_flag_win;
            r_den      <= {i_cfg.maxv, 1'b0};
            r_cnt      <= DIV_FIRST;
            r_quo      <= '0;
            r_sat      <= 1'b0;
            if (i_cfg.two) begin
                r_rem <= ({18'd0, e_v} << 17) - ({18'd0, e_v} << 1) + {18'd0, i_cfg.maxv};
            end else begin
                r_rem <= ({18'd0, e_v} << 9) - ({18'd0, e_v} << 1) + {18'd0, i_cfg.maxv};
            end
        end
        if (i_cmd.div_step) begin
            if (r_cnt == DIV_FIRST) begin
                r_sat <= d_ge;
            end else begin
                r_quo <= d_quo;
                if (d_ge) r_rem <= r_rem - d_trial;
            end
            r_cnt <= r_cnt - 5'd1;
            if (r_cnt == '0) begin
                r_b0 <= d_res[7:0];
                r_b1 <= d_res[15:8];
            end
        end
    end

    always_comb begin
        logic fin;
        fin             = i_cmd.sel_hi || (r_beats == 2'd1);
        o_out_byte      = i_cmd.sel_hi ? r_b1 : r_b0;
        o_row_end       = fin && r_flag_row;
        o_window_end    = fin && r_flag_win;
        o_sts.eval_beats = e_beats;
        o_sts.need_div   = e_need_div;
        o_sts.beats      = r_beats;
        o_sts.div_last   = (r_cnt == '0);
    end

endmodule

FILE: rtl/pnm_raster_window_convert_unit.sv
// Top level of the PNM raster window converter.
//
//  channel   direction  handshake                    payload
//  input     in         i_in_valid / o_in_stall      i_raster_byte
//  output    out        o_out_valid / i_out_stall    o_out_byte, o_row_end, o_window_end
//  config    in         i_cfg_wr_en                  i_cfg_index, i_cfg_data
//
// Each input beat is handled alone: load, evaluate, then no, one or two output beats.
// A byte outside the window gives no output beat; a copied byte may first be rescaled
// by a restoring divider, which yields one quotient bit per cycle, before its beats go out.
// Reset is synchronous and active low and returns position and configuration to defaults.
// A stalled output beat holds the block; no input beat is taken until all beats are out.
module pnm_raster_window_convert_unit
    import prwc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [7:0]            i_raster_byte,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [7:0]            o_out_byte,
    output logic                  o_row_end,
    output logic                  o_window_end,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;

    prwc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    prwc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    prwc_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_raster_byte (i_raster_byte),
        .i_cfg         (cfg),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_byte    (o_out_byte),
        .o_row_end     (o_row_end),
        .o_window_end  (o_window_end)
    );

`ifndef SYNTHESIS
    // An output beat on offer means no input beat can be taken.
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall) else $error("input taken while output pending");

    // The end of the window is always the end of a row.
    a_win_end_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_window_end) |-> o_row_end) else $error("window end without row end");

    // A freshly accepted beat is never offered in the next cycle.
    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> !o_out_valid) else $error("output too early");
`endif

endmodule
